@@ hdl/lirs_pkg.sv @@
// Shared constants, types and helper functions for the 48 kHz linear resampler.
`default_nettype none

package lirs_pkg;

  localparam int NATIVE_RATE = 48000;
  localparam int RATE_LOW    = 8000;
  localparam int RATE_HIGH   = 192000;
  localparam int MAX_RESULTS = 6;

  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 18;
  localparam int REM_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int FUO_W      = 3;
  localparam int STEPS_W    = 3;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int FRAC_MUL_W = 26;
  localparam int FRAC_PROD_W = REM_W + FRAC_MUL_W;
  localparam int FRAC_SHIFT = 25;

  // frac = floor(rem * 2^16 / 48000) = floor(rem * 512 / 375), exact for rem < 48000
  localparam logic [FRAC_MUL_W-1:0] FRAC_MUL = 26'd45812985;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(NATIVE_RATE);

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IS_8BIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_STEREO     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FRAC,
    ST_MUL,
    ST_OUT
  } lirs_state_e;

  typedef struct packed {
    logic capture;
    logic set_have_prev;
    logic dec_fuo;
    logic run_start;
    logic run_phase2;
    logic frac_step;
    logic mul_step;
    logic load_out;
    logic commit;
  } lirs_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic fuo_zero;
    logic fuo_one;
    logic last;
    logic more;
    logic out_free;
  } lirs_sts_t;

  // 8-bit unsigned becomes (s-128)<<8; 16-bit is taken as is
  function automatic logic [SAMPLE_W-1:0] to_s16(logic [SAMPLE_W-1:0] raw, logic depth8);
    logic [SAMPLE_W-1:0] res;
    if (depth8) begin
      res = {~raw[7], raw[6:0], 8'h00};
    end else begin
      res = raw;
    end
    return res;
  endfunction

  function automatic logic [RATE_W-1:0] rate_multiple(logic [STEPS_W-1:0] steps);
    logic [RATE_W-1:0] res;
    unique case (steps)
      3'd1:    res = RATE_W'(NATIVE_RATE);
      3'd2:    res = RATE_W'(2 * NATIVE_RATE);
      3'd3:    res = RATE_W'(3 * NATIVE_RATE);
      3'd4:    res = RATE_W'(4 * NATIVE_RATE);
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/lirs_in_if.sv @@
// Source frame channel: valid/ready with raw sample payload.
`default_nettype none

interface lirs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_left;
  logic [15:0] sample_right;
  logic        last_frame;

  modport source (output valid, output sample_left, output sample_right, output last_frame,
                  input ready);
  modport sink   (input valid, input sample_left, input sample_right, input last_frame,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/lirs_out_if.sv @@
// Result frame channel: valid/ready with 48 kHz stereo payload.
`default_nettype none

interface lirs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic               run_last;
  logic               stream_end;

  modport source (output valid, output out_left, output out_right, output run_last,
                  output stream_end, input ready);
  modport sink   (input valid, input out_left, input out_right, input run_last,
                  input stream_end, output ready);
endinterface

`default_nettype wire

@@ hdl/lirs_ctrl.sv @@
// Sequencing state machine: walks each request through its interpolation runs.
`default_nettype none

module lirs_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  lirs_pkg::lirs_sts_t  sts_i,
  output lirs_pkg::lirs_cmd_t  cmd_o
);

  lirs_pkg::lirs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lirs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == lirs_pkg::ST_IDLE);
    unique case (state_q)
      lirs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lirs_pkg::ST_START;
        end
      end
      lirs_pkg::ST_START: begin
        if (!sts_i.have_prev) begin
          // first frame of a stream: only a final frame emits here
          cmd_o.set_have_prev = 1'b1;
          if (sts_i.last) begin
            cmd_o.run_start  = 1'b1;
            cmd_o.run_phase2 = 1'b1;
            state_d          = lirs_pkg::ST_FRAC;
          end else begin
            cmd_o.commit = 1'b1;
            state_d      = lirs_pkg::ST_IDLE;
          end
        end else if (sts_i.fuo_zero) begin
          cmd_o.run_start = 1'b1;
          state_d         = lirs_pkg::ST_FRAC;
        end else begin
          cmd_o.dec_fuo = 1'b1;
          if (sts_i.last && sts_i.fuo_one) begin
            cmd_o.run_start  = 1'b1;
            cmd_o.run_phase2 = 1'b1;
            state_d          = lirs_pkg::ST_FRAC;
          end else begin
            cmd_o.commit = 1'b1;
            state_d      = lirs_pkg::ST_IDLE;
          end
        end
      end
      lirs_pkg::ST_FRAC: begin
        cmd_o.frac_step = 1'b1;
        state_d         = lirs_pkg::ST_MUL;
      end
      lirs_pkg::ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = lirs_pkg::ST_OUT;
      end
      lirs_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.more) begin
            state_d = lirs_pkg::ST_FRAC;
          end else begin
            cmd_o.commit = 1'b1;
            state_d      = lirs_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = lirs_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/lirs_dp.sv @@
// Datapath: config registers, stream state, phase accumulator, interpolation and output register.
`default_nettype none

module lirs_dp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [lirs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [lirs_pkg::RATE_W-1:0]           cfg_wdata_i,
  input  wire  [lirs_pkg::SAMPLE_W-1:0]         sample_left_i,
  input  wire  [lirs_pkg::SAMPLE_W-1:0]         sample_right_i,
  input  wire                                   last_frame_i,
  input  lirs_pkg::lirs_cmd_t                   cmd_i,
  output lirs_pkg::lirs_sts_t                   sts_o,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [lirs_pkg::SAMPLE_W-1:0]  out_left_o,
  output logic signed [lirs_pkg::SAMPLE_W-1:0]  out_right_o,
  output logic                                  out_run_last_o,
  output logic                                  out_stream_end_o
);

  localparam int SW = lirs_pkg::SAMPLE_W;

  // configuration
  logic [lirs_pkg::RATE_W-1:0] rate_q;
  logic                        depth8_q;
  logic                        stereo_q;

  // stream state
  logic [SW-1:0]                 prev_l_q, prev_r_q;
  logic                          have_prev_q, have_prev_d;
  logic [lirs_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [lirs_pkg::FUO_W-1:0]    fuo_q, fuo_d;

  // per-request working registers
  logic [SW-1:0]                 cur_l_q, cur_r_q;
  logic                          last_q;
  logic                          phase2_q, phase2_d;
  logic [lirs_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          more_q, more_d;
  logic [lirs_pkg::FRAC_W-1:0]   frac_q;
  logic                          a_sel_q;
  logic signed [lirs_pkg::PROD_W-1:0] prod_l_q, prod_r_q;
  logic                          out_valid_q;

  // ------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= lirs_pkg::RATE_RESET;
      depth8_q <= 1'b0;
      stereo_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lirs_pkg::CFG_SOURCE_RATE:   rate_q   <= cfg_wdata_i;
        lirs_pkg::CFG_DEPTH_IS_8BIT: depth8_q <= cfg_wdata_i[0];
        lirs_pkg::CFG_IS_STEREO:     stereo_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Phase advance: r = rem + rate, steps = r / 48000 by compares
  logic [lirs_pkg::RATE_W-1:0]  used_rate;
  logic [lirs_pkg::RATE_W-1:0]  r_sum;
  logic [lirs_pkg::RATE_W-1:0]  r_left;
  logic [lirs_pkg::STEPS_W-1:0] steps;
  logic                         steps_nz;
  logic                         cont;
  logic                         next_phase2;
  logic [lirs_pkg::CNT_W-1:0]   cnt_inc;

  always_comb begin
    if (rate_q < lirs_pkg::RATE_W'(lirs_pkg::RATE_LOW)) begin
      used_rate = lirs_pkg::RATE_W'(lirs_pkg::RATE_LOW);
    end else if (rate_q > lirs_pkg::RATE_W'(lirs_pkg::RATE_HIGH)) begin
      used_rate = lirs_pkg::RATE_W'(lirs_pkg::RATE_HIGH);
    end else begin
      used_rate = rate_q;
    end
  end

  assign r_sum = lirs_pkg::RATE_W'(rem_q) + used_rate;

  always_comb begin
    priority if (r_sum >= lirs_pkg::RATE_W'(4 * lirs_pkg::NATIVE_RATE)) steps = 3'd4;
    else if (r_sum >= lirs_pkg::RATE_W'(3 * lirs_pkg::NATIVE_RATE))      steps = 3'd3;
    else if (r_sum >= lirs_pkg::RATE_W'(2 * lirs_pkg::NATIVE_RATE))      steps = 3'd2;
    else if (r_sum >= lirs_pkg::RATE_W'(lirs_pkg::NATIVE_RATE))          steps = 3'd1;
    else                                                                 steps = 3'd0;
  end

  assign r_left   = r_sum - lirs_pkg::rate_multiple(steps);
  assign steps_nz = (steps != '0);
  assign cnt_inc  = cnt_q + 1'b1;

  // Does another result follow in this request?
  always_comb begin
    if (!phase2_q) begin
      if (!steps_nz) begin
        cont        = 1'b1;
        next_phase2 = 1'b0;
      end else if (last_q && (steps == 3'd1)) begin
        // run on the held frame ends exactly at the final frame: clamped run follows
        cont        = 1'b1;
        next_phase2 = 1'b1;
      end else begin
        cont        = 1'b0;
        next_phase2 = 1'b0;
      end
    end else begin
      cont        = !steps_nz;
      next_phase2 = 1'b1;
    end
  end

  // frac from the current remainder, exact reciprocal multiply
  logic [lirs_pkg::FRAC_PROD_W-1:0] frac_prod;
  assign frac_prod = lirs_pkg::FRAC_PROD_W'(rem_q) * lirs_pkg::FRAC_PROD_W'(lirs_pkg::FRAC_MUL);

  always_comb begin
    have_prev_d = have_prev_q;
    rem_d       = rem_q;
    fuo_d       = fuo_q;
    phase2_d    = phase2_q;
    cnt_d       = cnt_q;
    more_d      = more_q;
    if (cmd_i.capture) begin
      cnt_d = '0;
    end
    if (cmd_i.run_start) begin
      phase2_d = cmd_i.run_phase2;
    end
    if (cmd_i.set_have_prev) begin
      have_prev_d = 1'b1;
    end
    if (cmd_i.dec_fuo) begin
      fuo_d = fuo_q - 1'b1;
    end
    if (cmd_i.frac_step) begin
      rem_d    = r_left[lirs_pkg::REM_W-1:0];
      fuo_d    = fuo_q + steps - lirs_pkg::FUO_W'(!phase2_q && steps_nz);
      cnt_d    = cnt_inc;
      phase2_d = next_phase2;
      more_d   = cont && (cnt_inc != lirs_pkg::CNT_W'(lirs_pkg::MAX_RESULTS));
    end
    // end of stream clears the stream state
    if (cmd_i.commit && last_q) begin
      have_prev_d = 1'b0;
      rem_d       = '0;
      fuo_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      rem_q       <= '0;
      fuo_q       <= '0;
      phase2_q    <= 1'b0;
      cnt_q       <= '0;
      more_q      <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      have_prev_q <= have_prev_d;
      rem_q       <= rem_d;
      fuo_q       <= fuo_d;
      phase2_q    <= phase2_d;
      cnt_q       <= cnt_d;
      more_q      <= more_d;
      if (cmd_i.commit) begin
        prev_l_q <= last_q ? '0 : cur_l_q;
        prev_r_q <= last_q ? '0 : cur_r_q;
      end
    end
  end

  // ------------------------------------------------------------------
  // Frame capture, with sample format conversion
  logic [SW-1:0] conv_l, conv_r;
  assign conv_l = lirs_pkg::to_s16(sample_left_i, depth8_q);
  assign conv_r = stereo_q ? lirs_pkg::to_s16(sample_right_i, depth8_q) : conv_l;

  // ------------------------------------------------------------------
  // Interpolation: a + floor((b - a) * frac / 65536), full-width product
  // a_sel_q keeps the base of the result in flight; phase2_q already tracks the next one
  logic [SW-1:0] a_l, a_r;
  logic signed [lirs_pkg::DIFF_W-1:0] diff_l, diff_r, frac_s;

  assign a_l    = a_sel_q ? cur_l_q : prev_l_q;
  assign a_r    = a_sel_q ? cur_r_q : prev_r_q;
  assign diff_l = $signed({cur_l_q[SW-1], cur_l_q}) - $signed({a_l[SW-1], a_l});
  assign diff_r = $signed({cur_r_q[SW-1], cur_r_q}) - $signed({a_r[SW-1], a_r});
  assign frac_s = $signed({1'b0, frac_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_l_q <= conv_l;
      cur_r_q <= conv_r;
      last_q  <= last_frame_i;
    end
    if (cmd_i.frac_step) begin
      frac_q  <= frac_prod[lirs_pkg::FRAC_SHIFT +: lirs_pkg::FRAC_W];
      a_sel_q <= phase2_q;
    end
    if (cmd_i.mul_step) begin
      prod_l_q <= diff_l * frac_s;
      prod_r_q <= diff_r * frac_s;
    end
  end

  // ------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_left_o       <= $signed(a_l + prod_l_q[SW +: SW]);
      out_right_o      <= $signed(a_r + prod_r_q[SW +: SW]);
      out_run_last_o   <= !more_q;
      out_stream_end_o <= !more_q && last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.have_prev = have_prev_q;
  assign sts_o.fuo_zero  = (fuo_q == '0);
  assign sts_o.fuo_one   = (fuo_q == lirs_pkg::FUO_W'(1));
  assign sts_o.last      = last_q;
  assign sts_o.more      = more_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

@@ hdl/linear_interp_resampler_48k_top.sv @@
// Top level of the linear-interpolation resampler to 48 kHz stereo.
// A request passes ST_START, then ST_FRAC, ST_MUL and ST_OUT per result; it yields 0..6 results
//   and holds the input until all are loaded. Each result passes the phase/frac multiply, then the
//   interpolation multiply; ST_OUT loads it into the output register once the sink is free.
// Reset (rst_ni, async, active low): config returns to 48000 Hz, 16-bit, stereo; stream state
//   clears and the output register is emptied. No clearing pass.
`default_nettype none

module linear_interp_resampler_48k_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [lirs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [lirs_pkg::RATE_W-1:0]      cfg_wdata_i,
  lirs_in_if.sink                          in_i,
  lirs_out_if.source                       out_o
);

  lirs_pkg::lirs_cmd_t cmd;
  lirs_pkg::lirs_sts_t sts;
  logic                in_ready;

  lirs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lirs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_left_i    (in_i.sample_left),
    .sample_right_i   (in_i.sample_right),
    .last_frame_i     (in_i.last_frame),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_left_o       (out_o.out_left),
    .out_right_o      (out_o.out_right),
    .out_run_last_o   (out_o.run_last),
    .out_stream_end_o (out_o.stream_end)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

@@ hdl/lirs_checker.sv @@
// Port-level checks for the resampler top, attached by bind.
`default_nettype none

module lirs_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [15:0] out_left_i,
  input wire [15:0] out_right_i,
  input wire        out_run_last_i,
  input wire        out_stream_end_i
);

  // one request at a time: input closes right after a request
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted back to back");

  // end of stream is always the last result of its request
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!out_stream_end_i || out_run_last_i))
    else $error("stream_end without run_last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_left_i) &&
      $stable(out_right_i) && $stable(out_run_last_i) && $stable(out_stream_end_i)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind linear_interp_resampler_48k_top lirs_checker u_lirs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_left_i       (out_o.out_left),
  .out_right_i      (out_o.out_right),
  .out_run_last_i   (out_o.run_last),
  .out_stream_end_i (out_o.stream_end)
);

`default_nettype wire
